/* rtl/ssi_pkg.sv */
// Shared constants, widths, pipeline stage numbers and types for the
// segment / sphere intersection pipeline. No dependencies.
package ssi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RADIUS_W  = 31;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(((1 << FRAC_BITS) + 5) / 10);

    // squared lengths and dot products grow to 2*COORD_W+2 bits
    localparam int WIDE_W  = 2 * COORD_W + 2;
    localparam int ROOT_W  = COORD_W + 1;
    localparam int QUO_W   = COORD_W + 1;
    localparam int SQ_LAT  = ROOT_W;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int IN_DATA_W  = 6 * COORD_W;
    localparam int OUT_DATA_W = 6 * COORD_W;
    localparam int OUT_USER_W = 3;

    // tuser bit positions on the result side
    localparam int USR_PLUS  = 0;
    localparam int USR_MINUS = 1;
    localparam int USR_DEGEN = 2;

    // register stage numbers, counted from the input register
    localparam int ST_IN   = 1;
    localparam int ST_PROD = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_ABS  = 4;
    localparam int ST_LEN  = ST_ABS + SQ_LAT;
    localparam int ST_AVM  = ST_LEN + DIV_LAT;
    localparam int ST_SQR  = ST_AVM + 1;
    localparam int ST_DISC = ST_SQR + 1;
    localparam int ST_SQ   = ST_DISC + SQ_LAT;
    localparam int ST_T    = ST_SQ + 1;
    localparam int ST_MUL  = ST_T + 1;
    localparam int ST_Q    = ST_MUL + DIV_LAT;
    localparam int ST_OUT  = ST_Q + 1;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] a;
        logic [2:0][COORD_W-1:0] dmag;
        logic [2:0]              dneg;
        logic                    zero;
    } t_side;

endpackage

/* rtl/ssi_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on ssi_pkg.
module ssi_isqrt (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [ssi_pkg::WIDE_W-1:0] i_rad,
    output logic [ssi_pkg::ROOT_W-1:0] o_root
);

    logic [ssi_pkg::WIDE_W:0]   r_rem  [0:ssi_pkg::ROOT_W-1];
    logic [ssi_pkg::ROOT_W-1:0] r_root [0:ssi_pkg::ROOT_W-1];

    genvar j;
    generate
        for (j = 0; j < ssi_pkg::ROOT_W; j++) begin : g_stage
            localparam int B = ssi_pkg::ROOT_W - 1 - j;
            logic [ssi_pkg::WIDE_W:0]   rem_in;
            logic [ssi_pkg::WIDE_W:0]   trial;
            logic [ssi_pkg::ROOT_W-1:0] root_in;

            if (j == 0) begin : g_first
                assign rem_in  = {1'b0, i_rad};
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
            end

            // (root + 2^B)^2 - root^2; root has no bits at or below B
            assign trial = ((ssi_pkg::WIDE_W+1)'(root_in) << (B + 1))
                         | ((ssi_pkg::WIDE_W+1)'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (rem_in >= trial) begin
                        r_rem[j]  <= rem_in - trial;
                        r_root[j] <= root_in | (ssi_pkg::ROOT_W'(1) << B);
                    end else begin
                        r_rem[j]  <= rem_in;
                        r_root[j] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[ssi_pkg::ROOT_W-1];

endmodule

/* rtl/ssi_divr.sv */
// Pipelined restoring divider, one quotient bit per stage, then a
// round-half-up stage. Depends on ssi_pkg.
module ssi_divr (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [ssi_pkg::WIDE_W-1:0] i_num,
    input  logic [ssi_pkg::ROOT_W-1:0] i_den,
    output logic [ssi_pkg::QUO_W-1:0]  o_quo
);

    logic [ssi_pkg::WIDE_W-1:0] r_rem [0:ssi_pkg::QUO_W-1];
    logic [ssi_pkg::ROOT_W-1:0] r_den [0:ssi_pkg::QUO_W-1];
    logic [ssi_pkg::QUO_W-1:0]  r_quo [0:ssi_pkg::QUO_W-1];
    logic [ssi_pkg::QUO_W-1:0]  r_out;

    genvar j;
    generate
        for (j = 0; j < ssi_pkg::QUO_W; j++) begin : g_stage
            localparam int I = ssi_pkg::QUO_W - 1 - j;
            logic [ssi_pkg::WIDE_W-1:0] rem_in;
            logic [ssi_pkg::WIDE_W-1:0] sub;
            logic [ssi_pkg::ROOT_W-1:0] den_in;
            logic [ssi_pkg::QUO_W-1:0]  quo_in;

            if (j == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign den_in = r_den[j-1];
                assign quo_in = r_quo[j-1];
            end

            assign sub = ssi_pkg::WIDE_W'(den_in) << I;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_den[j] <= den_in;
                    if (rem_in >= sub) begin
                        r_rem[j] <= rem_in - sub;
                        r_quo[j] <= quo_in | (ssi_pkg::QUO_W'(1) << I);
                    end else begin
                        r_rem[j] <= rem_in;
                        r_quo[j] <= quo_in;
                    end
                end
            end
        end
    endgenerate

    // round half away from zero: bump when 2*rem >= den
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= r_quo[ssi_pkg::QUO_W-1]
                   + ssi_pkg::QUO_W'({r_rem[ssi_pkg::QUO_W-1], 1'b0}
                                     >= (ssi_pkg::WIDE_W+1)'(r_den[ssi_pkg::QUO_W-1]));
        end
    end

    assign o_quo = r_out;

endmodule

/* rtl/segment_sphere_intersect_unit.sv */
// The result register is stage ssi_pkg::ST_OUT, counted from the input register.
// Throughput: one item per cycle while the output is not stalled; the pipeline depth
// is set by two 33-stage square roots and two rounds of 34-stage dividers in series.
// A stalled output freezes every stage at once; nothing is dropped.
// Reset (synchronous, active low) clears all valid bits and loads radius 6554.
// Depends on ssi_pkg, ssi_isqrt, ssi_divr.
module segment_sphere_intersect_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_radius_we,
    input  logic [ssi_pkg::RADIUS_W-1:0]     i_radius_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [ssi_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // plus_x, plus_y, plus_z, minus_x, minus_y, minus_z
    output logic [ssi_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // plus_hit, minus_hit, degenerate
    output logic [ssi_pkg::OUT_USER_W-1:0]   o_m_tuser
);

    localparam int CW = ssi_pkg::COORD_W;
    localparam int WW = ssi_pkg::WIDE_W;
    localparam int RW = ssi_pkg::ROOT_W;
    localparam int QW = ssi_pkg::QUO_W;

    logic ce;

    logic [ssi_pkg::RADIUS_W-1:0] r_radius;
    logic                         r_vld   [ssi_pkg::ST_IN:ssi_pkg::ST_OUT];
    ssi_pkg::t_side               r_side  [ssi_pkg::ST_IN:ssi_pkg::ST_Q];
    ssi_pkg::t_side               n_side;

    logic [2:0][2*CW-1:0] r_pdd, r_paa, r_pad, n_pdd, n_paa, n_pad;
    logic [2:0]           r_psg, n_psg;

    logic [WW-1:0] r_dd, r_ppos, r_pneg, n_dd, n_aa, n_ppos, n_pneg;
    logic [WW-1:0] r_aa   [ssi_pkg::ST_SUM:ssi_pkg::ST_SQR];
    logic [WW-1:0] r_dd4;
    logic [WW-1:0] r_pm   [ssi_pkg::ST_ABS:ssi_pkg::ST_LEN];
    logic          r_psgn [ssi_pkg::ST_ABS:ssi_pkg::ST_SQ];

    logic [RW-1:0] w_len;
    logic [RW-1:0] r_len  [ssi_pkg::ST_LEN+1:ssi_pkg::ST_MUL];
    logic [QW-1:0] w_avm;
    logic [QW-1:0] r_avm  [ssi_pkg::ST_SQR:ssi_pkg::ST_SQ];
    logic [WW-1:0] r_avsq, r_rsq, r_dif, n_disc;
    logic          r_neg  [ssi_pkg::ST_DISC:ssi_pkg::ST_SQ];
    logic [RW-1:0] w_sq;

    logic [1:0][RW-1:0] r_t, n_t;
    logic [1:0]         r_hit [ssi_pkg::ST_T:ssi_pkg::ST_Q];
    logic [1:0]         n_hit;
    logic [1:0][2:0][WW-1:0] r_prod;
    logic [1:0][2:0][QW-1:0] w_q;

    logic [5:0][CW-1:0]  r_out_data, n_out_data;
    logic [ssi_pkg::OUT_USER_W-1:0] r_out_user, n_out_user;

    assign ce         = !r_vld[ssi_pkg::ST_OUT] || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[ssi_pkg::ST_OUT];
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= ssi_pkg::RADIUS_RST;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = ssi_pkg::ST_IN; k <= ssi_pkg::ST_OUT; k++) r_vld[k] <= 1'b0;
        end else if (ce) begin
            r_vld[ssi_pkg::ST_IN] <= i_s_tvalid;
            for (int k = ssi_pkg::ST_IN + 1; k <= ssi_pkg::ST_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: direction and its sign/magnitude
    always_comb begin
        logic [CW:0]   dif;
        logic [CW-1:0] st;
        logic [CW-1:0] en;
        n_side = '0;
        for (int k = 0; k < 3; k++) begin
            st  = i_s_tdata[k*CW +: CW];
            en  = i_s_tdata[(k+3)*CW +: CW];
            dif = {en[CW-1], en} - {st[CW-1], st};
            n_side.a[k]    = st;
            n_side.dneg[k] = dif[CW];
            n_side.dmag[k] = dif[CW] ? CW'(-dif) : dif[CW-1:0];
        end
        n_side.zero = (n_side.dmag == '0);
    end

    // stage 2: squares and cross products of magnitudes
    always_comb begin
        logic [CW-1:0] amag;
        for (int k = 0; k < 3; k++) begin
            amag     = r_side[ssi_pkg::ST_IN].a[k][CW-1] ? -r_side[ssi_pkg::ST_IN].a[k]
                                                         : r_side[ssi_pkg::ST_IN].a[k];
            n_pdd[k] = (2*CW)'(r_side[ssi_pkg::ST_IN].dmag[k])
                     * (2*CW)'(r_side[ssi_pkg::ST_IN].dmag[k]);
            n_paa[k] = (2*CW)'(amag) * (2*CW)'(amag);
            n_pad[k] = (2*CW)'(amag) * (2*CW)'(r_side[ssi_pkg::ST_IN].dmag[k]);
            n_psg[k] = r_side[ssi_pkg::ST_IN].a[k][CW-1] ^ r_side[ssi_pkg::ST_IN].dneg[k];
        end
    end

    // stage 3: sums
    always_comb begin
        n_dd   = WW'(r_pdd[0]) + WW'(r_pdd[1]) + WW'(r_pdd[2]);
        n_aa   = WW'(r_paa[0]) + WW'(r_paa[1]) + WW'(r_paa[2]);
        n_ppos = '0;
        n_pneg = '0;
        for (int k = 0; k < 3; k++) begin
            if (r_psg[k]) n_pneg = n_pneg + WW'(r_pad[k]);
            else          n_ppos = n_ppos + WW'(r_pad[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[ssi_pkg::ST_IN] <= n_side;
            for (int k = ssi_pkg::ST_IN + 1; k <= ssi_pkg::ST_Q; k++) r_side[k] <= r_side[k-1];
            r_pdd <= n_pdd;
            r_paa <= n_paa;
            r_pad <= n_pad;
            r_psg <= n_psg;
            r_dd   <= n_dd;
            r_ppos <= n_ppos;
            r_pneg <= n_pneg;
            r_aa[ssi_pkg::ST_SUM] <= n_aa;
            for (int k = ssi_pkg::ST_SUM + 1; k <= ssi_pkg::ST_SQR; k++) r_aa[k] <= r_aa[k-1];
            // stage 4: |A.D| and its sign
            r_dd4 <= r_dd;
            r_psgn[ssi_pkg::ST_ABS] <= (r_ppos < r_pneg);
            r_pm[ssi_pkg::ST_ABS]   <= (r_ppos < r_pneg) ? r_pneg - r_ppos : r_ppos - r_pneg;
            for (int k = ssi_pkg::ST_ABS + 1; k <= ssi_pkg::ST_LEN; k++) r_pm[k] <= r_pm[k-1];
            for (int k = ssi_pkg::ST_ABS + 1; k <= ssi_pkg::ST_SQ; k++) r_psgn[k] <= r_psgn[k-1];
            r_len[ssi_pkg::ST_LEN+1] <= w_len;
            for (int k = ssi_pkg::ST_LEN + 2; k <= ssi_pkg::ST_MUL; k++) r_len[k] <= r_len[k-1];
            // discriminant
            r_avm[ssi_pkg::ST_SQR] <= w_avm;
            for (int k = ssi_pkg::ST_SQR + 1; k <= ssi_pkg::ST_SQ; k++) r_avm[k] <= r_avm[k-1];
            r_avsq <= WW'(w_avm) * WW'(w_avm);
            r_rsq  <= WW'(r_radius) * WW'(r_radius);
            r_neg[ssi_pkg::ST_DISC] <= (n_disc < r_aa[ssi_pkg::ST_SQR]);
            for (int k = ssi_pkg::ST_DISC + 1; k <= ssi_pkg::ST_SQ; k++) r_neg[k] <= r_neg[k-1];
            r_dif <= n_disc - r_aa[ssi_pkg::ST_SQR];
            // roots and the offsets along the segment
            r_t <= n_t;
            r_hit[ssi_pkg::ST_T] <= n_hit;
            for (int k = ssi_pkg::ST_T + 1; k <= ssi_pkg::ST_Q; k++) r_hit[k] <= r_hit[k-1];
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[s][k] <= WW'(r_t[s]) * WW'(r_side[ssi_pkg::ST_T].dmag[k]);
                end
            end
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign n_disc = r_avsq + r_rsq;

    ssi_isqrt u_len_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  (r_dd4),
        .o_root (w_len)
    );

    ssi_divr u_av_div (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_pm[ssi_pkg::ST_LEN]),
        .i_den (w_len),
        .o_quo (w_avm)
    );

    ssi_isqrt u_disc_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_rad  (r_dif),
        .o_root (w_sq)
    );

    // t = -av +/- sq, hit when the discriminant is not negative, the segment is not degenerate and 0 <= t <= len
    always_comb begin
        logic signed [RW+1:0] av;
        logic signed [RW+1:0] sq;
        logic signed [RW+1:0] tp;
        logic signed [RW+1:0] tm;
        logic                 ok;
        sq = signed'({2'b00, w_sq});
        av = r_psgn[ssi_pkg::ST_SQ] ? -signed'({2'b00, r_avm[ssi_pkg::ST_SQ]})
                                    : signed'({2'b00, r_avm[ssi_pkg::ST_SQ]});
        tp = sq - av;
        tm = -av - sq;
        ok = !r_neg[ssi_pkg::ST_SQ] && !r_side[ssi_pkg::ST_SQ].zero;
        n_hit[0] = ok && !tp[RW+1] && (tp[RW:0] <= {1'b0, r_len[ssi_pkg::ST_SQ]});
        n_hit[1] = ok && !tm[RW+1] && (tm[RW:0] <= {1'b0, r_len[ssi_pkg::ST_SQ]});
        n_t[0]   = tp[RW-1:0];
        n_t[1]   = tm[RW-1:0];
    end

    genvar gs, gk;
    generate
        for (gs = 0; gs < 2; gs++) begin : g_root
            for (gk = 0; gk < 3; gk++) begin : g_comp
                ssi_divr u_pt_div (
                    .i_clk (i_clk),
                    .i_ce  (ce),
                    .i_num (r_prod[gs][gk]),
                    .i_den (r_len[ssi_pkg::ST_MUL]),
                    .o_quo (w_q[gs][gk])
                );
            end
        end
    endgenerate

    // final point A + signed offset, saturated, zero when no hit
    always_comb begin
        logic signed [QW+1:0] off;
        logic signed [QW+1:0] sum;
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 3; k++) begin
                off = r_side[ssi_pkg::ST_Q].dneg[k] ? -signed'({2'b00, w_q[s][k]})
                                                    : signed'({2'b00, w_q[s][k]});
                sum = signed'((QW+2)'(signed'(r_side[ssi_pkg::ST_Q].a[k]))) + off;
                if (!r_hit[ssi_pkg::ST_Q][s]) begin
                    n_out_data[s*3+k] = '0;
                end else if (sum[QW+1:CW-1] != '0 && sum[QW+1:CW-1] != '1) begin
                    n_out_data[s*3+k] = sum[QW+1] ? {1'b1, {(CW-1){1'b0}}}
                                                  : {1'b0, {(CW-1){1'b1}}};
                end else begin
                    n_out_data[s*3+k] = sum[CW-1:0];
                end
            end
        end
        n_out_user[ssi_pkg::USR_PLUS]  = r_hit[ssi_pkg::ST_Q][0];
        n_out_user[ssi_pkg::USR_MINUS] = r_hit[ssi_pkg::ST_Q][1];
        n_out_user[ssi_pkg::USR_DEGEN] = r_side[ssi_pkg::ST_Q].zero;
    end

    a_degen_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[ssi_pkg::USR_DEGEN]
        |-> !o_m_tuser[ssi_pkg::USR_PLUS] && !o_m_tuser[ssi_pkg::USR_MINUS])
        else $error("degenerate segment reported a hit");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while pipeline frozen");

    a_plus_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[ssi_pkg::USR_PLUS] |-> o_m_tdata[3*CW-1:0] == '0)
        else $error("plus point not cleared on miss");

    a_minus_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[ssi_pkg::USR_MINUS] |-> o_m_tdata[6*CW-1:3*CW] == '0)
        else $error("minus point not cleared on miss");

endmodule

/* dv/tb_segment_sphere_intersect_unit.sv */
// Testbench for segment_sphere_intersect_unit: directed and random segments
// against a self-contained fixed-point predictor, with random stalls on both sides.
// Depends on ssi_pkg and the RTL of the unit.
module tb_segment_sphere_intersect_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [129:0] t_wide;

    typedef struct {
        logic                             plus_hit;
        logic [2:0][ssi_pkg::COORD_W-1:0] plus_p;
        logic                             minus_hit;
        logic [2:0][ssi_pkg::COORD_W-1:0] minus_p;
        logic                             degenerate;
    } t_hit_result;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam int     RECV_HOLD = 400;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_radius_we;
    logic [ssi_pkg::RADIUS_W-1:0]     i_radius_wdata;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [ssi_pkg::IN_DATA_W-1:0]    i_s_tdata;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [ssi_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic [ssi_pkg::OUT_USER_W-1:0]   o_m_tuser;

    segment_sphere_intersect_unit dut (.*);

    t_hit_result      pending_hits[$];
    logic [ssi_pkg::RADIUS_W-1:0] radius_now;
    int               mismatches;
    bit               quiet_mode;   // no random idling on either side
    bit               hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_segment_sphere_intersect_unit failed");
        $finish;
    end

    function automatic t_wide int_sqrt(t_wide n);
        t_wide r;
        t_wide c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (t_wide'(1) << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // quotient rounded half away from zero, both operands non-negative
    function automatic t_wide div_round(t_wide n, t_wide d);
        t_wide q;
        t_wide r;
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        return q;
    endfunction

    function automatic t_hit_result solve_segment(logic [ssi_pkg::IN_DATA_W-1:0] seg,
                                                  logic [ssi_pkg::RADIUS_W-1:0] rad);
        t_hit_result res;
        t_wide ak[3];
        t_wide dk[3];
        t_wide dd, dot, aa, len, avm, av, disc, sq, t, q, v, rw;
        res = '{default: '0};
        dd = 0; dot = 0; aa = 0;
        for (int k = 0; k < 3; k++) begin
            ak[k] = $signed(seg[ssi_pkg::COORD_W*k +: ssi_pkg::COORD_W]);
            dk[k] = $signed(seg[ssi_pkg::COORD_W*(k+3) +: ssi_pkg::COORD_W]);
            dk[k] = dk[k] - ak[k];
            dd  = dd + dk[k] * dk[k];
            dot = dot + ak[k] * dk[k];
            aa  = aa + ak[k] * ak[k];
        end
        if (dd == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        len = int_sqrt(dd);
        avm = div_round(dot < 0 ? -dot : dot, len);
        av  = dot < 0 ? -avm : avm;
        rw  = t_wide'(rad);
        disc = avm * avm + rw * rw;
        if (disc < aa) return res;
        sq = int_sqrt(disc - aa);
        for (int s = 0; s < 2; s++) begin
            t = s == 0 ? -av + sq : -av - sq;
            if (t < 0 || t > len) continue;
            for (int k = 0; k < 3; k++) begin
                q = div_round(t * (dk[k] < 0 ? -dk[k] : dk[k]), len);
                v = ak[k] + (dk[k] < 0 ? -q : q);
                if (v > COORD_MAX) v = COORD_MAX;
                if (v < COORD_MIN) v = COORD_MIN;
                if (s == 0) res.plus_p[k] = v[ssi_pkg::COORD_W-1:0];
                else        res.minus_p[k] = v[ssi_pkg::COORD_W-1:0];
            end
            if (s == 0) res.plus_hit = 1'b1;
            else        res.minus_hit = 1'b1;
        end
        return res;
    endfunction

    // sender: valid is only raised or kept here; lowered by idle or end_stream
    task automatic send_segment(logic [ssi_pkg::IN_DATA_W-1:0] seg);
        if (!quiet_mode && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= seg;
        do @(posedge i_clk); while (!o_s_tready);
        pending_hits.push_back(solve_segment(seg, radius_now));
    endtask

    task automatic end_stream();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_hits.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (160) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [ssi_pkg::RADIUS_W-1:0] value);
        drain();
        i_radius_we    <= 1'b1;
        i_radius_wdata <= value;
        @(posedge i_clk);
        i_radius_we <= 1'b0;
        radius_now  = value;
        @(posedge i_clk);
    endtask

    function automatic logic [ssi_pkg::IN_DATA_W-1:0] pack_seg(
        longint sx, longint sy, longint sz, longint ex, longint ey, longint ez);
        return {ez[31:0], ey[31:0], ex[31:0], sz[31:0], sy[31:0], sx[31:0]};
    endfunction

    function automatic longint near_coord(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic logic [ssi_pkg::IN_DATA_W-1:0] random_segment();
        longint span;
        int     pick;
        logic [ssi_pkg::IN_DATA_W-1:0] seg;
        pick = $urandom_range(0, 9);
        span = 3 * longint'(radius_now) + 16;
        if (span > COORD_MAX / 2) span = COORD_MAX / 2;
        if (pick < 2) begin
            for (int k = 0; k < 6; k++) seg[32*k +: 32] = $urandom;
        end else begin
            seg = pack_seg(near_coord(span), near_coord(span), near_coord(span),
                           near_coord(span), near_coord(span), near_coord(span));
            if (pick == 9) seg[191:96] = seg[95:0];
        end
        return seg;
    endfunction

    always @(posedge i_clk) begin
        t_hit_result exp_r;
        t_hit_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.plus_p     = o_m_tdata[95:0];
            got.minus_p    = o_m_tdata[191:96];
            got.plus_hit   = o_m_tuser[ssi_pkg::USR_PLUS];
            got.minus_hit  = o_m_tuser[ssi_pkg::USR_MINUS];
            got.degenerate = o_m_tuser[ssi_pkg::USR_DEGEN];
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h %h",
                                               o_m_tuser, o_m_tdata);
            end else begin
                exp_r = pending_hits.pop_front();
                if (got.plus_hit !== exp_r.plus_hit || got.plus_p !== exp_r.plus_p
                    || got.minus_hit !== exp_r.minus_hit || got.minus_p !== exp_r.minus_p
                    || got.degenerate !== exp_r.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp hits %b%b%b plus %h minus %h",
                                 exp_r.degenerate, exp_r.minus_hit, exp_r.plus_hit,
                                 exp_r.plus_p, exp_r.minus_p);
                        $display("         got hits %b%b%b plus %h minus %h",
                                 got.degenerate, got.minus_hit, got.plus_hit,
                                 got.plus_p, got.minus_p);
                    end
                end
            end
        end
    end

    // receiver stalls; a hold request gives one long back-pressure stretch
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left = RECV_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= quiet_mode || $urandom_range(0, 99) >= 20;
            end
        end
    end

    task automatic test_directed();
        longint r;
        r = radius_now;
        send_segment(pack_seg(5, -7, 9, 5, -7, 9));                 // zero length
        send_segment(pack_seg(0, 0, 0, 0, 0, 0));
        send_segment(pack_seg(-2*r, 0, 0, 2*r, 0, 0));              // through center
        send_segment(pack_seg(2*r, 0, 0, -2*r, 0, 0));
        send_segment(pack_seg(0, -2*r, 0, 0, 2*r, 1));
        send_segment(pack_seg(-2*r, r, 0, 2*r, r, 0));              // tangent
        send_segment(pack_seg(-2*r, 3*r, 0, 2*r, 3*r, 0));          // misses
        send_segment(pack_seg(-r/4, 0, 0, r/4, 0, 0));              // inside sphere
        send_segment(pack_seg(0, 0, -2*r, 0, 0, 0));                // one root on segment
        send_segment(pack_seg(0, 0, 0, 0, 0, 2*r));
        send_segment(pack_seg(COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(pack_seg(COORD_MAX, COORD_MIN, COORD_MAX,
                              COORD_MIN, COORD_MAX, COORD_MIN));
        send_segment(pack_seg(COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(pack_seg(-1, -1, -1, 1, 1, 1));
        end_stream();
    endtask

    task automatic test_extreme_radius();
        write_radius('0);
        test_directed();
        write_radius({ssi_pkg::RADIUS_W{1'b1}});
        test_directed();
        repeat (10) send_segment(random_segment());
        end_stream();
    endtask

    task automatic test_random(int count, logic [ssi_pkg::RADIUS_W-1:0] rad);
        write_radius(rad);
        for (int i = 0; i < count; i++) begin
            quiet_mode = i >= count / 2 && i < count / 2 + 60;
            send_segment(random_segment());
        end
        quiet_mode = 1'b0;
        end_stream();
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 250; i++) send_segment(random_segment());
        end_stream();
    endtask

    initial begin
        mismatches     = 0;
        quiet_mode     = 1'b0;
        hold_request   = 1'b0;
        radius_now     = ssi_pkg::RADIUS_RST;
        i_rst_n        = 1'b0;
        i_radius_we    = 1'b0;
        i_radius_wdata = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150, ssi_pkg::RADIUS_RST);
        test_extreme_radius();
        test_random(200, 31'd1);
        test_random(200, 31'($urandom_range(1 << 10, 1 << 28)));
        test_backpressure();
        drain();

        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("tb_segment_sphere_intersect_unit passed");
        end else begin
            $display("tb_segment_sphere_intersect_unit failed");
        end
        $finish;
    end
endmodule
